[sv/sorted_merge_buffer_assert.svh]
// Assertion macros for the merge buffer.
`ifndef SORTED_MERGE_BUFFER_ASSERT_SVH
`define SORTED_MERGE_BUFFER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SMB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SMB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/smb_pkg.sv]
`default_nettype none

package smb_pkg;

    localparam int SMB_DEPTH_DEFAULT = 16;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

    // one held record; seq in the low bits, matches the stream packing
    typedef struct packed {
        logic [3:0]  src;
        logic [31:0] pos;
        logic [31:0] seq;
    } rec_t;

    // one result item
    typedef struct packed {
        status_t    status;
        rec_t       rec;
        logic [4:0] occ;
    } res_t;

    // key of a strictly greater than key of b, lexicographic, signed
    function automatic logic key_greater(input rec_t a, input rec_t b);
        if (a.seq != b.seq)
        begin
            return $signed(a.seq) > $signed(b.seq);
        end
        return $signed(a.pos) > $signed(b.pos);
    endfunction

endpackage

`default_nettype wire

[sv/smb_mem.sv]
`default_nettype none

module smb_mem
    import smb_pkg::*;
#(
    parameter int DEPTH = SMB_DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire rec_t          wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output rec_t               rdata
);

    rec_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/smb_walk.sv]
`default_nettype none

module smb_walk
    import smb_pkg::*;
#(
    parameter int DEPTH = SMB_DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    // item in
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_kind,
    input  wire rec_t          in_rec,
    // result out
    output logic               res_valid,
    input  wire logic          res_ready,
    output res_t               res,
    // memory port
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output rec_t               mem_wdata,
    output logic               mem_re,
    output logic [AW-1:0]      mem_raddr,
    input  wire rec_t          mem_rdata
);

    localparam int SW = AW + 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_WALK   = 5'b00010,
        S_PLACE  = 5'b00100,
        S_POPRD  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   hole_reg, hole_next;
    rec_t            new_reg, new_next;
    res_t            res_reg, res_next;

    // logical slot -> physical address in the ring
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] h);
        logic [SW-1:0] sum;
        sum = SW'(hd) + SW'(h);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        hole_next  = hole_reg;
        new_next   = new_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = phys(head_reg, hole_reg);
        mem_wdata  = new_reg;
        mem_re     = 1'b0;
        mem_raddr  = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    new_next = in_rec;
                    hole_next = count_reg;
                    res_next = '{status: STS_OK, rec: '0, occ: 5'(count_reg)};
                    if (in_kind == KIND_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = STS_EMPTY;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            mem_re = 1'b1;
                            mem_raddr = head_reg;
                            state_next = S_POPRD;
                        end
                    end
                    else if (count_reg == CW'(DEPTH))
                    begin
                        res_next.status = STS_FULL;
                        state_next = S_RESULT;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        mem_re = 1'b1;
                        mem_raddr = phys(head_reg, count_reg - CW'(1));
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                // read data holds the entry just below the hole
                mem_we = 1'b1;
                if (key_greater(mem_rdata, new_reg))
                begin
                    mem_wdata = mem_rdata;
                    hole_next = hole_reg - CW'(1);
                    if (hole_reg == CW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        mem_re = 1'b1;
                        mem_raddr = phys(head_reg, hole_reg - CW'(2));
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    res_next.occ = 5'(count_reg + CW'(1));
                    state_next = S_RESULT;
                end
            end
            S_PLACE:
            begin
                mem_we = 1'b1;
                count_next = count_reg + CW'(1);
                res_next.occ = 5'(count_reg + CW'(1));
                state_next = S_RESULT;
            end
            S_POPRD:
            begin
                res_next.rec = mem_rdata;
                res_next.occ = 5'(count_reg - CW'(1));
                count_next = count_reg - CW'(1);
                head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg <= hole_next;
        new_reg  <= new_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

[sv/sorted_merge_buffer.sv]
// Sorted merge buffer: keeps up to DEPTH records ordered by (seq_index, position),
// signed, equal keys in arrival order, to drive a k-way merge of sorted streams.
// Input channel s_*: s_tuser is the kind (0 insert, 1 pop the smallest record).
// Output channel m_*: one transfer per input transfer; m_tuser is the status
// (0 ok, 1 pop on empty, 2 insert into full), m_tdata the popped record and the
// occupancy after the item. Failed items leave the contents untouched.
// Records sit in a ring inside one RAM with registered read data. A pop reads
// the head. An insert walks from the tail toward the head, one entry per cycle,
// moving each larger record up one slot. A rejected item goes straight to
// the result. One item is in the walker at a time; s_tready is high only while
// it is idle, so no new item is taken until the result has left the walker.
// The output register holds a finished result while m_tready is low; the
// walker then waits with its own result and takes no new item.
// Reset (rst_n low, asynchronous) empties the buffer; no clearing pass runs.
`default_nettype none

`include "sorted_merge_buffer_assert.svh"

module sorted_merge_buffer
    import smb_pkg::*;
#(
    parameter int DEPTH = SMB_DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,  // seq_index[31:0], position[63:32], source[67:64]
    input  wire logic [0:0]  s_tuser,  // kind[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,  // out_seq_index[31:0], out_position[63:32],
                                       // out_source[67:64], occupancy[72:68]
    output logic [1:0]       m_tuser   // status[1:0]
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    rec_t          mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    rec_t          mem_rdata;

    logic          res_valid;
    logic          res_ready;
    res_t          res;

    logic          m_tvalid_reg;
    res_t          out_reg;

    smb_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    smb_walk #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser[0]),
        .in_rec    (rec_t'(s_tdata[67:0])),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // output register: loads when empty or draining this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'b0, out_reg.occ, out_reg.rec.src, out_reg.rec.pos, out_reg.rec.seq};

    // an accepted item always keeps the walker busy the next cycle
    `SMB_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "walker took an item while busy")
    // a stalled result from the walker holds steady
    `SMB_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "walker result changed under stall")
    // a failed pop reports an empty buffer
    `SMB_ASSERT_NOW(a_empty_occ, m_tvalid && m_tuser == STS_EMPTY, m_tdata[72:68] == 5'd0, "empty status with records held")
    // a failed insert reports a full buffer
    `SMB_ASSERT_NOW(a_full_occ, m_tvalid && m_tuser == STS_FULL, m_tdata[72:68] == 5'(DEPTH), "full status below depth")

endmodule

`default_nettype wire
